>>> rtl/core/q8sf_pkg.sv
// ----------------------------------------------------------------------------
// q8sf_pkg
// Shared constants, widths and types of the eight-node quadrilateral
// shape function evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package q8sf_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COORD_W   = 16;
    localparam int RES_W     = 16;

    localparam int ONE_W = FRAC_BITS + 2;
    localparam int OP_W  = ((ONE_W > COORD_W + 1) ? ONE_W : COORD_W + 1) + 1;
    localparam int P1_W  = 2 * OP_W;
    localparam int V_W   = P1_W + 2;
    localparam int T_W   = V_W - FRAC_BITS;
    localparam int P2_W  = T_W + OP_W;
    localparam int R_W   = P2_W + 1;

    localparam longint ONE_VAL  = 64'sd1 <<< FRAC_BITS;
    localparam longint ONE2_VAL = ONE_VAL * ONE_VAL;
    localparam longint HALF_F0  = ONE_VAL >>> 1;
    localparam longint HALF_F1  = ONE_VAL;
    localparam longint HALF_F2  = ONE_VAL <<< 1;

    localparam longint RES_MAX_VAL = (64'sd1 <<< (RES_W - 1)) - 64'sd1;
    localparam longint RES_MIN_VAL = -(64'sd1 <<< (RES_W - 1));

    typedef enum logic [1:0] {
        OP_VALUE,
        OP_DXI,
        OP_DETA,
        OP_DZETA
    } op_t;

    typedef enum logic [1:0] {
        SH_F0,
        SH_F1,
        SH_F2
    } sh1_t;

    typedef enum logic {
        SH2_F1,
        SH2_F2
    } sh2_t;

    typedef struct packed {
        logic sub;
        logic neg;
        sh1_t sh1;
        logic mult2;
        sh2_t sh2;
    } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/q8sf_req_if.sv
// ----------------------------------------------------------------------------
// q8sf_req_if
// Request channel: operation, node and master coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface q8sf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [2:0]  node;
    logic signed [15:0] xi;
    logic signed [15:0] eta;

    modport source (output valid, output operation, output node, output xi, output eta,
                    input ready);
    modport sink   (input valid, input operation, input node, input xi, input eta,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/q8sf_rsp_if.sv
// ----------------------------------------------------------------------------
// q8sf_rsp_if
// Response channel: one saturated fixed point result.
// ----------------------------------------------------------------------------
`default_nettype none

interface q8sf_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/quad8_shape_function_eval.sv
// ----------------------------------------------------------------------------
// quad8_shape_function_eval
// Eight-node serendipity quadrilateral shape functions and their
// derivatives at a master point, in a five-stage pipeline.
//
//   channel    dir   payload
//   request    in    operation[1:0], node[2:0], xi[15:0], eta[15:0]
//   response   out   result[15:0]
//
// One transfer per cycle in each direction unless the output register is blocked.
// Stages: operand select, first multiply, offset and round, second
// multiply, round and saturate. The two multipliers set the depth.
// Advance all stages when the output register is empty or taken; else hold.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module quad8_shape_function_eval (
    input  wire logic      clk,
    input  wire logic      rst_n,
    q8sf_req_if.sink       request,
    q8sf_rsp_if.source     response
);

    localparam int OP_W = q8sf_pkg::OP_W;
    localparam int T_W  = q8sf_pkg::T_W;

    logic                   en;
    logic                   s1_valid, s3_valid, s5_valid;
    logic signed [OP_W-1:0] s1_a, s1_b, s1_c, s3_c;
    q8sf_pkg::ctl_t         s1_ctl, s3_ctl;
    logic signed [T_W-1:0]  s3_t;

    assign en            = response.ready || !s5_valid;
    assign request.ready = en;

    q8sf_operand u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (request.valid),
        .operation (request.operation),
        .node      (request.node),
        .xi        (request.xi),
        .eta       (request.eta),
        .out_valid (s1_valid),
        .a         (s1_a),
        .b         (s1_b),
        .c         (s1_c),
        .ctl       (s1_ctl)
    );

    q8sf_first_product u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .a         (s1_a),
        .b         (s1_b),
        .c         (s1_c),
        .ctl       (s1_ctl),
        .out_valid (s3_valid),
        .t         (s3_t),
        .c_out     (s3_c),
        .ctl_out   (s3_ctl)
    );

    q8sf_second_product u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid),
        .t         (s3_t),
        .c         (s3_c),
        .ctl       (s3_ctl),
        .out_valid (s5_valid),
        .result    (response.result)
    );

    assign response.valid = s5_valid;

`ifndef SYNTH
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (s1_valid == $past(request.valid)))
        else $error("stage one valid does not follow an advancing request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({s1_valid, s3_valid, s5_valid}))
        else $error("pipeline valid bits moved during a stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid && !response.ready) |-> !request.ready)
        else $error("request taken while the output register is blocked");
`endif

endmodule

`default_nettype wire

>>> rtl/core/q8sf_operand.sv
// ----------------------------------------------------------------------------
// q8sf_operand
// Stage 1: pick the multiplier operands and rounding control for the
// requested operation and node.
// ----------------------------------------------------------------------------
`default_nettype none

module q8sf_operand (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           operation,
    input  wire logic [2:0]           node,
    input  wire logic signed [15:0]   xi,
    input  wire logic signed [15:0]   eta,
    output logic                      out_valid,
    output logic signed [q8sf_pkg::OP_W-1:0] a,
    output logic signed [q8sf_pkg::OP_W-1:0] b,
    output logic signed [q8sf_pkg::OP_W-1:0] c,
    output q8sf_pkg::ctl_t            ctl
);

    localparam int OP_W = q8sf_pkg::OP_W;
    localparam logic signed [OP_W-1:0] ONE_C = OP_W'(q8sf_pkg::ONE_VAL);

    logic signed [OP_W-1:0] x_e, y_e;
    logic signed [OP_W-1:0] omx, opx, omy, opy, tx2, ty2;
    logic signed [OP_W-1:0] a_next, b_next, c_next;
    q8sf_pkg::ctl_t         ctl_next;
    q8sf_pkg::ctl_t         ctl_corner, ctl_mid, ctl_prod0, ctl_prod2, ctl_sqr;
    logic                   valid_reg;
    logic signed [OP_W-1:0] a_reg, b_reg, c_reg;
    q8sf_pkg::ctl_t         ctl_reg;

    always_comb
    begin
        x_e = OP_W'(xi);
        y_e = OP_W'(eta);
        omx = ONE_C - x_e;
        opx = ONE_C + x_e;
        omy = ONE_C - y_e;
        opy = ONE_C + y_e;
        tx2 = x_e <<< 1;
        ty2 = y_e <<< 1;

        ctl_corner = '{sub: 1'b0, neg: 1'b0, sh1: q8sf_pkg::SH_F0, mult2: 1'b1,
                       sh2: q8sf_pkg::SH2_F2};
        ctl_mid    = '{sub: 1'b1, neg: 1'b0, sh1: q8sf_pkg::SH_F0, mult2: 1'b1,
                       sh2: q8sf_pkg::SH2_F1};
        ctl_prod0  = '{sub: 1'b0, neg: 1'b0, sh1: q8sf_pkg::SH_F0, mult2: 1'b0,
                       sh2: q8sf_pkg::SH2_F1};
        ctl_prod2  = '{sub: 1'b0, neg: 1'b0, sh1: q8sf_pkg::SH_F2, mult2: 1'b0,
                       sh2: q8sf_pkg::SH2_F1};
        ctl_sqr    = '{sub: 1'b1, neg: 1'b0, sh1: q8sf_pkg::SH_F1, mult2: 1'b0,
                       sh2: q8sf_pkg::SH2_F1};

        a_next   = '0;
        b_next   = '0;
        c_next   = '0;
        ctl_next = ctl_prod0;

        unique case (q8sf_pkg::op_t'(operation))
            q8sf_pkg::OP_VALUE:
            begin
                unique case (node)
                    3'd0:
                    begin
                        a_next = omx; b_next = omy; c_next = -ONE_C - x_e - y_e;
                        ctl_next = ctl_corner;
                    end
                    3'd1:
                    begin
                        a_next = x_e; b_next = x_e; c_next = omy; ctl_next = ctl_mid;
                    end
                    3'd2:
                    begin
                        a_next = opx; b_next = omy; c_next = -ONE_C + x_e - y_e;
                        ctl_next = ctl_corner;
                    end
                    3'd3:
                    begin
                        a_next = y_e; b_next = y_e; c_next = opx; ctl_next = ctl_mid;
                    end
                    3'd4:
                    begin
                        a_next = opx; b_next = opy; c_next = -ONE_C + x_e + y_e;
                        ctl_next = ctl_corner;
                    end
                    3'd5:
                    begin
                        a_next = x_e; b_next = x_e; c_next = opy; ctl_next = ctl_mid;
                    end
                    3'd6:
                    begin
                        a_next = omx; b_next = opy; c_next = -ONE_C - x_e + y_e;
                        ctl_next = ctl_corner;
                    end
                    default:
                    begin
                        a_next = y_e; b_next = y_e; c_next = omx; ctl_next = ctl_mid;
                    end
                endcase
            end
            q8sf_pkg::OP_DXI:
            begin
                unique case (node)
                    3'd0:    begin a_next = omy; b_next = tx2 + y_e; ctl_next = ctl_prod2; end
                    3'd1:    begin a_next = x_e; b_next = y_e - ONE_C; end
                    3'd2:    begin a_next = omy; b_next = tx2 - y_e; ctl_next = ctl_prod2; end
                    3'd3:    begin a_next = y_e; b_next = y_e; ctl_next = ctl_sqr; end
                    3'd4:    begin a_next = opy; b_next = tx2 + y_e; ctl_next = ctl_prod2; end
                    3'd5:    begin a_next = -x_e; b_next = opy; end
                    3'd6:    begin a_next = opy; b_next = tx2 - y_e; ctl_next = ctl_prod2; end
                    default:
                    begin
                        a_next = y_e; b_next = y_e;
                        ctl_next = ctl_sqr;
                        ctl_next.neg = 1'b1;
                    end
                endcase
            end
            q8sf_pkg::OP_DETA:
            begin
                unique case (node)
                    3'd0:    begin a_next = omx; b_next = x_e + ty2; ctl_next = ctl_prod2; end
                    3'd1:
                    begin
                        a_next = x_e; b_next = x_e;
                        ctl_next = ctl_sqr;
                        ctl_next.neg = 1'b1;
                    end
                    3'd2:    begin a_next = opx; b_next = ty2 - x_e; ctl_next = ctl_prod2; end
                    3'd3:    begin a_next = -y_e; b_next = opx; end
                    3'd4:    begin a_next = opx; b_next = x_e + ty2; ctl_next = ctl_prod2; end
                    3'd5:    begin a_next = x_e; b_next = x_e; ctl_next = ctl_sqr; end
                    3'd6:    begin a_next = omx; b_next = ty2 - x_e; ctl_next = ctl_prod2; end
                    default: begin a_next = y_e; b_next = x_e - ONE_C; end
                endcase
            end
            default:
            begin
                a_next = '0;
                b_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign a         = a_reg;
    assign b         = b_reg;
    assign c         = c_reg;
    assign ctl       = ctl_reg;

endmodule

`default_nettype wire

>>> rtl/core/q8sf_first_product.sv
// ----------------------------------------------------------------------------
// q8sf_first_product
// Stages 2 and 3: first product, optional offset by one squared, and
// rounding shift back to the fixed point scale.
// ----------------------------------------------------------------------------
`default_nettype none

module q8sf_first_product (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [q8sf_pkg::OP_W-1:0] a,
    input  wire logic signed [q8sf_pkg::OP_W-1:0] b,
    input  wire logic signed [q8sf_pkg::OP_W-1:0] c,
    input  wire q8sf_pkg::ctl_t       ctl,
    output logic                      out_valid,
    output logic signed [q8sf_pkg::T_W-1:0]  t,
    output logic signed [q8sf_pkg::OP_W-1:0] c_out,
    output q8sf_pkg::ctl_t            ctl_out
);

    localparam int OP_W = q8sf_pkg::OP_W;
    localparam int P1_W = q8sf_pkg::P1_W;
    localparam int V_W  = q8sf_pkg::V_W;
    localparam int T_W  = q8sf_pkg::T_W;
    localparam int F    = q8sf_pkg::FRAC_BITS;
    localparam logic signed [V_W-1:0] ONE2_C = V_W'(q8sf_pkg::ONE2_VAL);
    localparam logic signed [V_W-1:0] H0_C   = V_W'(q8sf_pkg::HALF_F0);
    localparam logic signed [V_W-1:0] H1_C   = V_W'(q8sf_pkg::HALF_F1);
    localparam logic signed [V_W-1:0] H2_C   = V_W'(q8sf_pkg::HALF_F2);

    logic signed [P1_W-1:0] prod;
    logic signed [P1_W-1:0] p1_reg;
    logic signed [OP_W-1:0] c2_reg, c3_reg;
    q8sf_pkg::ctl_t         ctl2_reg, ctl3_reg;
    logic                   valid2_reg, valid3_reg;
    logic signed [V_W-1:0]  p1_e, v;
    logic signed [V_W-1:0]  s0, s1, s2;
    logic signed [T_W-1:0]  t_next, t_reg;

    assign prod = a * b;

    always_comb
    begin
        p1_e = V_W'(p1_reg);
        if (!ctl2_reg.sub)
        begin
            v = p1_e;
        end
        else if (ctl2_reg.neg)
        begin
            v = p1_e - ONE2_C;
        end
        else
        begin
            v = ONE2_C - p1_e;
        end

        s0 = (v + H0_C) >>> F;
        s1 = (v + H1_C) >>> (F + 1);
        s2 = (v + H2_C) >>> (F + 2);

        unique case (ctl2_reg.sh1)
            q8sf_pkg::SH_F1: t_next = s1[T_W-1:0];
            q8sf_pkg::SH_F2: t_next = s2[T_W-1:0];
            default:         t_next = s0[T_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid2_reg <= in_valid;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= prod;
            c2_reg   <= c;
            ctl2_reg <= ctl;
            t_reg    <= t_next;
            c3_reg   <= c2_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign t         = t_reg;
    assign c_out     = c3_reg;
    assign ctl_out   = ctl3_reg;

endmodule

`default_nettype wire

>>> rtl/core/q8sf_second_product.sv
// ----------------------------------------------------------------------------
// q8sf_second_product
// Stages 4 and 5: optional second product and final rounding shift, then
// saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module q8sf_second_product (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [q8sf_pkg::T_W-1:0]  t,
    input  wire logic signed [q8sf_pkg::OP_W-1:0] c,
    input  wire q8sf_pkg::ctl_t       ctl,
    output logic                      out_valid,
    output logic signed [q8sf_pkg::RES_W-1:0] result
);

    localparam int P2_W  = q8sf_pkg::P2_W;
    localparam int R_W   = q8sf_pkg::R_W;
    localparam int RES_W = q8sf_pkg::RES_W;
    localparam int F     = q8sf_pkg::FRAC_BITS;
    localparam logic signed [R_W-1:0] H1_C   = R_W'(q8sf_pkg::HALF_F1);
    localparam logic signed [R_W-1:0] H2_C   = R_W'(q8sf_pkg::HALF_F2);
    localparam logic signed [R_W-1:0] SAT_HI = R_W'(q8sf_pkg::RES_MAX_VAL);
    localparam logic signed [R_W-1:0] SAT_LO = R_W'(q8sf_pkg::RES_MIN_VAL);

    logic signed [P2_W-1:0]  prod, p2_next, p2_reg;
    q8sf_pkg::ctl_t          ctl4_reg;
    logic                    valid4_reg, valid5_reg;
    logic signed [R_W-1:0]   p2_e, r;
    logic signed [RES_W-1:0] result_next, result_reg;

    assign prod    = t * c;
    assign p2_next = ctl.mult2 ? prod : P2_W'(t);

    always_comb
    begin
        p2_e = R_W'(p2_reg);
        if (!ctl4_reg.mult2)
        begin
            r = p2_e;
        end
        else
        begin
            unique case (ctl4_reg.sh2)
                q8sf_pkg::SH2_F2: r = (p2_e + H2_C) >>> (F + 2);
                default:          r = (p2_e + H1_C) >>> (F + 1);
            endcase
        end

        priority if (r > SAT_HI)
        begin
            result_next = SAT_HI[RES_W-1:0];
        end
        else if (r < SAT_LO)
        begin
            result_next = SAT_LO[RES_W-1:0];
        end
        else
        begin
            result_next = r[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else if (en)
        begin
            valid4_reg <= in_valid;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg     <= p2_next;
            ctl4_reg   <= ctl;
            result_reg <= result_next;
        end
    end

    assign out_valid = valid5_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> tb/sv/shape_board_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shape_board_pkg
// Expected-result store for the quadrilateral shape function evaluator.
// Computes each serendipity shape value or derivative in fixed point, with
// the evaluator's rounding and saturation. Compares responses in order.
// ----------------------------------------------------------------------------
package shape_board_pkg;

    import q8sf_pkg::*;

    typedef struct {
        op_t                op;
        logic [2:0]         node;
        logic signed [15:0] xi;
        logic signed [15:0] eta;
        logic signed [15:0] result;
    } shape_expect_t;

    class shape_board;

        localparam int     FB      = FRAC_BITS;
        localparam longint UNIT    = 64'sd1 <<< FB;
        localparam longint UNIT_SQ = UNIT <<< FB;

        shape_expect_t pending_results[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("tb_top: shape mismatch: %s", msg);
            errors++;
        endtask

        function longint round_shift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint mul_round(longint a, longint b, int s);
            return round_shift(a * b, s);
        endfunction

        function longint shape_eval(op_t op, logic [2:0] node, longint x, longint y);
            longint r;
            r = 0;
            case (op)
                OP_VALUE:
                begin
                    case (node)
                        3'd0: r = mul_round(mul_round(UNIT - x, UNIT - y, FB), -UNIT - x - y, FB + 2);
                        3'd1: r = mul_round(round_shift(UNIT_SQ - x * x, FB), UNIT - y, FB + 1);
                        3'd2: r = mul_round(mul_round(UNIT + x, UNIT - y, FB), -UNIT + x - y, FB + 2);
                        3'd3: r = mul_round(round_shift(UNIT_SQ - y * y, FB), UNIT + x, FB + 1);
                        3'd4: r = mul_round(mul_round(UNIT + x, UNIT + y, FB), -UNIT + x + y, FB + 2);
                        3'd5: r = mul_round(round_shift(UNIT_SQ - x * x, FB), UNIT + y, FB + 1);
                        3'd6: r = mul_round(mul_round(UNIT - x, UNIT + y, FB), -UNIT - x + y, FB + 2);
                        default: r = mul_round(round_shift(UNIT_SQ - y * y, FB), UNIT - x, FB + 1);
                    endcase
                end
                OP_DXI:
                begin
                    case (node)
                        3'd0: r = mul_round(UNIT - y, 2 * x + y, FB + 2);
                        3'd1: r = mul_round(x, y - UNIT, FB);
                        3'd2: r = mul_round(UNIT - y, 2 * x - y, FB + 2);
                        3'd3: r = round_shift(UNIT_SQ - y * y, FB + 1);
                        3'd4: r = mul_round(UNIT + y, 2 * x + y, FB + 2);
                        3'd5: r = mul_round(-x, UNIT + y, FB);
                        3'd6: r = mul_round(UNIT + y, 2 * x - y, FB + 2);
                        default: r = round_shift(y * y - UNIT_SQ, FB + 1);
                    endcase
                end
                OP_DETA:
                begin
                    case (node)
                        3'd0: r = mul_round(UNIT - x, x + 2 * y, FB + 2);
                        3'd1: r = round_shift(x * x - UNIT_SQ, FB + 1);
                        3'd2: r = mul_round(UNIT + x, 2 * y - x, FB + 2);
                        3'd3: r = mul_round(-y, UNIT + x, FB);
                        3'd4: r = mul_round(UNIT + x, x + 2 * y, FB + 2);
                        3'd5: r = round_shift(UNIT_SQ - x * x, FB + 1);
                        3'd6: r = mul_round(UNIT - x, 2 * y - x, FB + 2);
                        default: r = mul_round(y, x - UNIT, FB);
                    endcase
                end
                default: r = 0;
            endcase
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        task note_request(op_t op, logic [2:0] node, logic signed [15:0] xi,
                          logic signed [15:0] eta);
            shape_expect_t e;
            e.op     = op;
            e.node   = node;
            e.xi     = xi;
            e.eta    = eta;
            e.result = 16'(shape_eval(op, node, longint'(xi), longint'(eta)));
            pending_results.push_back(e);
        endtask

        task check_result(logic signed [15:0] got);
            shape_expect_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d with no request pending", got));
            end
            else
            begin
                e = pending_results.pop_front();
                if (got !== e.result)
                    report($sformatf("%s node %0d xi %0d eta %0d: got %0d, expected %0d",
                                     e.op.name(), e.node, e.xi, e.eta, got, e.result));
            end
        endtask

    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams shape function requests into the evaluator under varying source
// gaps and sink stalls, and checks every response in order against a
// fixed point model of the eight-node serendipity functions.
// ----------------------------------------------------------------------------
module tb_top;

    import q8sf_pkg::*;
    import shape_board_pkg::*;

    logic clk;
    logic rst_n;
    logic hold_off = 1'b0;
    int   stall_pct = 0;
    int   idle_pct = 0;

    shape_board board;

    q8sf_req_if request_ch();
    q8sf_rsp_if response_ch();

    quad8_shape_function_eval uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            response_ch.ready <= 1'b0;
        else
            response_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_ch.valid && request_ch.ready)
                board.note_request(op_t'(request_ch.operation), request_ch.node,
                                   request_ch.xi, request_ch.eta);
            if (response_ch.valid && response_ch.ready)
                board.check_result(response_ch.result);
        end
    end

    task automatic send_request(op_t op, logic [2:0] node, logic signed [15:0] xi,
                                logic signed [15:0] eta);
        while ($urandom_range(99) < idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid     <= 1'b1;
        request_ch.operation <= op;
        request_ch.node      <= node;
        request_ch.xi        <= xi;
        request_ch.eta       <= eta;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(9))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    task automatic send_random();
        send_request(op_t'($urandom_range(3)), 3'($urandom_range(7)), pick_coord(),
                     pick_coord());
    endtask

    task automatic drain_results();
        request_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic hold_sink(int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    initial
    begin
        logic signed [15:0] edge_vals[5];
        int send_pcts[4];
        int stall_pcts[4];
        board = new();
        edge_vals  = '{-16'sd16384, 16'sd16384, 16'sd0, -16'sd1, 16'sd1};
        send_pcts  = '{0, 45, 0, 34};
        stall_pcts = '{0, 0, 45, 34};
        clk                  = 1'b0;
        rst_n                = 1'b0;
        request_ch.valid     = 1'b0;
        request_ch.operation = OP_VALUE;
        request_ch.node      = 3'd0;
        request_ch.xi        = 16'sd0;
        request_ch.eta       = 16'sd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 24; k++)
            send_request(op_t'((k / 8 + k) % 4), 3'(k % 8), edge_vals[k % 5],
                         edge_vals[(k / 5) % 5]);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = send_pcts[ph];
            stall_pct <= stall_pcts[ph];
            for (int i = 0; i < 238; i++)
            begin
                if (ph == 0 && i == 40)
                    fork
                        hold_sink(150);
                    join_none
                if (ph == 2 && i == 119)
                    drain_results();
                send_random();
            end
            drain_results();
        end

        repeat (12) @(posedge clk);
        if (board.pending_results.size() != 0)
            board.report($sformatf("%0d results never arrived",
                                   board.pending_results.size()));
        if (board.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/core/q8sf_pkg.sv
rtl/core/q8sf_req_if.sv
rtl/core/q8sf_rsp_if.sv
rtl/core/q8sf_operand.sv
rtl/core/q8sf_first_product.sv
rtl/core/q8sf_second_product.sv
rtl/core/quad8_shape_function_eval.sv
tb/sv/shape_board_pkg.sv
tb/sv/tb_top.sv
